/* hdl/bamr_pkg.sv */
// ----------------------------------------------------------------------------
// Bus address map package
// Shared types and constants for the bus address map registers block.
// ----------------------------------------------------------------------------
`default_nettype none

package bamr_pkg;

    localparam int ENTRY_COUNT = 32;
    localparam int ENTRY_W     = $clog2(ENTRY_COUNT);
    localparam int PHYS_W      = 22;
    localparam int BUS_W       = 18;
    localparam int OFF_W       = 13;
    localparam int BYTE_W      = 8;
    localparam int HIGH_W      = PHYS_W - 2 * BYTE_W;
    localparam int REGOFF_W    = 7;

    localparam logic [PHYS_W-1:0]  IO_PAGE_BASE = 22'o17760000;
    localparam logic [ENTRY_W-1:0] PAGE_IO      = 5'o37;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_XLATE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        LANE_LOW  = 2'd0,
        LANE_MID  = 2'd1,
        LANE_HIGH = 2'd2,
        LANE_NONE = 2'd3
    } t_lane;

    typedef enum logic {
        CFG_MAP_ENABLE  = 1'b0,
        CFG_MAP_PRESENT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOOK = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/bamr_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bamr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/bamr_ctrl.sv */
// ----------------------------------------------------------------------------
// Bus address map controller
// Sequences table lookup and completion of one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module bamr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bamr_pkg::t_sts i_sts,
    output bamr_pkg::t_cmd     o_cmd
);

    import bamr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/bamr_dp.sv */
// ----------------------------------------------------------------------------
// Bus address map datapath
// Relocation table, byte lane access, address translation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bamr_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic                          i_cfg_data,
    input  wire logic [1:0]                    i_action,
    input  wire logic [bamr_pkg::REGOFF_W-1:0] i_reg_offset,
    input  wire logic [bamr_pkg::BYTE_W-1:0]   i_write_byte,
    input  wire logic [bamr_pkg::BUS_W-1:0]    i_bus_address,
    input  wire logic                          i_out_stall,
    input  wire bamr_pkg::t_cmd                i_cmd,
    output bamr_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    output logic      [bamr_pkg::BYTE_W-1:0]   o_read_byte,
    output logic      [bamr_pkg::PHYS_W-1:0]   o_physical_address
);

    import bamr_pkg::*;

    logic                r_map_enable;
    logic                r_map_present;
    logic [ENTRY_COUNT-1:0] r_valid;
    logic                r_rd_valid;
    t_action             r_action;
    t_lane               r_lane;
    logic [ENTRY_W-1:0]  r_entry;
    logic [BYTE_W-1:0]   r_wbyte;
    logic [BUS_W-1:0]    r_addr;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_read_byte;
    logic [PHYS_W-1:0]   r_phys;

    logic [ENTRY_W-1:0]  rd_addr;
    logic [PHYS_W-1:0]   ram_q;
    logic [PHYS_W-1:0]   ent;
    logic [PHYS_W-1:0]   wr_value;
    logic                wr_en;
    logic [BYTE_W-1:0]   n_read_byte;
    logic [PHYS_W-1:0]   n_phys;
    logic [OFF_W-1:0]    page_off;
    logic [ENTRY_W-1:0]  page;

    always_comb begin
        if (t_action'(i_action) == ACT_XLATE) begin
            rd_addr = i_bus_address[BUS_W-1:OFF_W];
        end else begin
            rd_addr = i_reg_offset[REGOFF_W-1:2];
        end
    end

    bamr_ram #(
        .WIDTH (PHYS_W),
        .DEPTH (ENTRY_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_entry),
        .i_wdata (wr_value),
        .i_re    (i_cmd.load),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign ent      = r_rd_valid ? ram_q : '0;
    assign page     = r_addr[BUS_W-1:OFF_W];
    assign page_off = r_addr[OFF_W-1:0];

    always_comb begin
        n_read_byte = '0;
        n_phys      = '0;
        wr_value    = ent;
        wr_en       = 1'b0;
        unique case (r_action)
            ACT_READ: begin
                unique case (r_lane)
                    LANE_LOW:  n_read_byte = {ent[BYTE_W-1:1], 1'b0};
                    LANE_MID:  n_read_byte = ent[2*BYTE_W-1:BYTE_W];
                    LANE_HIGH: n_read_byte = {{(BYTE_W-HIGH_W){1'b0}}, ent[PHYS_W-1:2*BYTE_W]};
                    LANE_NONE: n_read_byte = '0;
                    default:   n_read_byte = '0;
                endcase
            end
            ACT_WRITE: begin
                unique case (r_lane)
                    LANE_LOW: begin
                        wr_value = {ent[PHYS_W-1:BYTE_W], r_wbyte[BYTE_W-1:1], 1'b0};
                        wr_en    = i_cmd.finish;
                    end
                    LANE_MID: begin
                        wr_value = {ent[PHYS_W-1:2*BYTE_W], r_wbyte, ent[BYTE_W-1:0]};
                        wr_en    = i_cmd.finish;
                    end
                    LANE_HIGH: begin
                        wr_value = {r_wbyte[HIGH_W-1:0], ent[2*BYTE_W-1:0]};
                        wr_en    = i_cmd.finish;
                    end
                    LANE_NONE: wr_en = 1'b0;
                    default:   wr_en = 1'b0;
                endcase
            end
            ACT_XLATE: begin
                if (!r_map_present || !r_map_enable) begin
                    n_phys = {{(PHYS_W-BUS_W){1'b0}}, r_addr};
                end else if (page == PAGE_IO) begin
                    n_phys = IO_PAGE_BASE + {{(PHYS_W-OFF_W){1'b0}}, page_off};
                end else begin
                    n_phys = ent + {{(PHYS_W-OFF_W){1'b0}}, page_off};
                end
            end
            ACT_NONE: begin
                n_phys = '0;
            end
            default: begin
                n_phys = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_enable  <= 1'b0;
            r_map_present <= 1'b1;
            r_valid       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MAP_ENABLE:  r_map_enable  <= i_cfg_data;
                    CFG_MAP_PRESENT: r_map_present <= i_cfg_data;
                    default: ;
                endcase
            end
            if (wr_en) begin
                r_valid[r_entry] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= t_action'(i_action);
            r_lane     <= t_lane'(i_reg_offset[1:0]);
            r_entry    <= i_reg_offset[REGOFF_W-1:2];
            r_wbyte    <= i_write_byte;
            r_addr     <= i_bus_address;
            r_rd_valid <= r_valid[rd_addr];
        end
        if (i_cmd.finish) begin
            r_read_byte <= n_read_byte;
            r_phys      <= n_phys;
        end
    end

    assign o_sts.out_busy      = r_out_valid && i_out_stall;
    assign o_out_valid         = r_out_valid;
    assign o_read_byte         = r_read_byte;
    assign o_physical_address  = r_phys;

endmodule

`default_nettype wire

/* hdl/bus_address_map_registers.sv */
// ----------------------------------------------------------------------------
// Bus address map registers
// Thirty-two relocation registers with byte access and 18-to-22 bit address
// translation.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall i_action, i_reg_offset,
//                                              i_write_byte, i_bus_address
// out       output     o_out_valid/ i_out_stall o_read_byte, o_physical_address
// cfg       input      i_cfg_we                i_cfg_index, i_cfg_data
//
// Each item passes through a registered table read, then forms the result and
// writes the table back.
// The result register must be free before an item completes, so a stalled
// output holds the block in the state that forms the result.
// Reset is synchronous; the table entries are cleared at once through
// per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_address_map_registers (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic                          i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_action,
    input  wire logic [bamr_pkg::REGOFF_W-1:0] i_reg_offset,
    input  wire logic [bamr_pkg::BYTE_W-1:0]   i_write_byte,
    input  wire logic [bamr_pkg::BUS_W-1:0]    i_bus_address,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [bamr_pkg::BYTE_W-1:0]   o_read_byte,
    output logic      [bamr_pkg::PHYS_W-1:0]   o_physical_address
);

    import bamr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bamr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bamr_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_action           (i_action),
        .i_reg_offset       (i_reg_offset),
        .i_write_byte       (i_write_byte),
        .i_bus_address      (i_bus_address),
        .i_out_stall        (i_out_stall),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .o_read_byte        (o_read_byte),
        .o_physical_address (o_physical_address)
    );

endmodule

`default_nettype wire

/* hdl/bamr_chk.sv */
// ----------------------------------------------------------------------------
// Bus address map checker
// Port-level properties of the bus address map registers block.
// ----------------------------------------------------------------------------
`default_nettype none

module bamr_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [bamr_pkg::BYTE_W-1:0]   o_read_byte,
    input wire logic [bamr_pkg::PHYS_W-1:0]   o_physical_address
);

    import bamr_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("item accepted while another is in work");

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_read_byte == '0 || o_physical_address == '0))
        else $error("both result fields nonzero");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !o_out_valid |=> ##1 o_out_valid)
        else $error("result late with free output");

endmodule

bind bus_address_map_registers bamr_chk u_bamr_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_read_byte        (o_read_byte),
    .o_physical_address (o_physical_address)
);

`default_nettype wire

/* test/bamr_map_checker.sv */
// ----------------------------------------------------------------------------
// Bus address map checker
// Watches the configuration port and both channels of the bus address map,
// keeps its own relocation table and map settings, predicts the result of
// every accepted item and compares each returned result field by field.
// ----------------------------------------------------------------------------

module bamr_map_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_action,
    input  logic [bamr_pkg::REGOFF_W-1:0] i_reg_offset,
    input  logic [bamr_pkg::BYTE_W-1:0]   i_write_byte,
    input  logic [bamr_pkg::BUS_W-1:0]    i_bus_address,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [bamr_pkg::BYTE_W-1:0]   i_read_byte,
    input  logic [bamr_pkg::PHYS_W-1:0]   i_physical_address,
    output int                            o_errors,
    output int                            o_pending
);

    import bamr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [PHYS_W-1:0] physical_address;
    } t_map_result;

    logic [PHYS_W-1:0] relocation_table [ENTRY_COUNT];
    logic              map_enable_q;
    logic              map_present_q;
    t_map_result       results_due [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s, got %0h, expected %0h", $time, what, got, want);
        o_errors++;
    endtask

    function automatic t_map_result map_access(input t_action act,
                                               input logic [REGOFF_W-1:0] offset,
                                               input logic [BYTE_W-1:0] wbyte,
                                               input logic [BUS_W-1:0] addr);
        t_map_result       res;
        logic [ENTRY_W-1:0] entry;
        t_lane             lane;
        logic [PHYS_W-1:0] word;
        logic [ENTRY_W-1:0] page;
        logic [PHYS_W-1:0] page_offset;
        res         = '0;
        entry       = offset[REGOFF_W-1:2];
        lane        = t_lane'(offset[1:0]);
        word        = relocation_table[entry];
        page        = addr[BUS_W-1:OFF_W];
        page_offset = {{(PHYS_W-OFF_W){1'b0}}, addr[OFF_W-1:0]};
        case (act)
            ACT_READ: begin
                case (lane)
                    LANE_LOW:  res.read_byte = {word[7:1], 1'b0};
                    LANE_MID:  res.read_byte = word[15:8];
                    LANE_HIGH: res.read_byte = {2'b00, word[PHYS_W-1:16]};
                    default:   res.read_byte = '0;
                endcase
            end
            ACT_WRITE: begin
                case (lane)
                    LANE_LOW:  relocation_table[entry] = {word[PHYS_W-1:8], wbyte[7:1], 1'b0};
                    LANE_MID:  relocation_table[entry] = {word[PHYS_W-1:16], wbyte, word[7:0]};
                    LANE_HIGH: relocation_table[entry] = {wbyte[HIGH_W-1:0], word[15:0]};
                    default:   ;
                endcase
            end
            ACT_XLATE: begin
                if (!map_present_q || !map_enable_q) begin
                    res.physical_address = {{(PHYS_W-BUS_W){1'b0}}, addr};
                end else if (page == PAGE_IO) begin
                    res.physical_address = IO_PAGE_BASE + page_offset;
                end else begin
                    res.physical_address = relocation_table[page] + page_offset;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_map_result due;
        if (!i_rst_n) begin
            foreach (relocation_table[i]) relocation_table[i] = '0;
            map_enable_q  = 1'b0;
            map_present_q = 1'b1;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_MAP_ENABLE:  map_enable_q  = i_cfg_data;
                    CFG_MAP_PRESENT: map_present_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no item outstanding",
                                    32'(i_physical_address), 0);
                end else begin
                    due = results_due.pop_front();
                    if (i_read_byte !== due.read_byte) begin
                        report_mismatch("read_byte", 32'(i_read_byte), 32'(due.read_byte));
                    end
                    if (i_physical_address !== due.physical_address) begin
                        report_mismatch("physical_address", 32'(i_physical_address),
                                        32'(due.physical_address));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(map_access(t_action'(i_action), i_reg_offset,
                                                 i_write_byte, i_bus_address));
            end
        end
        o_pending = results_due.size();
    end

endmodule

/* test/bus_address_map_registers_test.sv */
// ----------------------------------------------------------------------------
// Bus address map registers testbench
// Drives directed and random byte reads, byte writes and address translations
// through the bus address map under several map settings and idle patterns;
// a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module bus_address_map_registers_test;

    import bamr_pkg::*;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic                i_cfg_index   = 1'b0;
    logic                i_cfg_data    = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_action      = '0;
    logic [REGOFF_W-1:0] i_reg_offset  = '0;
    logic [BYTE_W-1:0]   i_write_byte  = '0;
    logic [BUS_W-1:0]    i_bus_address = '0;
    logic                o_out_valid;
    logic                i_out_stall   = 1'b0;
    logic [BYTE_W-1:0]   o_read_byte;
    logic [PHYS_W-1:0]   o_physical_address;

    int map_errors;
    int map_pending;
    int idle_pct  = 0;
    int stall_pct = 0;

    bus_address_map_registers dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_reg_offset       (i_reg_offset),
        .i_write_byte       (i_write_byte),
        .i_bus_address      (i_bus_address),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_read_byte        (o_read_byte),
        .o_physical_address (o_physical_address)
    );

    bamr_map_checker checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_reg_offset       (i_reg_offset),
        .i_write_byte       (i_write_byte),
        .i_bus_address      (i_bus_address),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_read_byte        (o_read_byte),
        .i_physical_address (o_physical_address),
        .o_errors           (map_errors),
        .o_pending          (map_pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(input t_action act, input logic [REGOFF_W-1:0] offset,
                             input logic [BYTE_W-1:0] wbyte, input logic [BUS_W-1:0] addr);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_reg_offset  <= offset;
        i_write_byte  <= wbyte;
        i_bus_address <= addr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic settle(input int extra_cycles);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (map_pending != 0) @(negedge i_clk);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    task automatic write_map_regs(input logic enable, input logic present);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAP_ENABLE;
        i_cfg_data  <= enable;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAP_PRESENT;
        i_cfg_data  <= present;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        t_action              act;
        logic [REGOFF_W-1:0]  offset;
        logic [BYTE_W-1:0]    wbyte;
        logic [BUS_W-1:0]     addr;
        int                   pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(ACT_XLATE, 7'd0, 8'h00, 18'h00000);
        send_item(ACT_XLATE, 7'd0, 8'h00, 18'h3FFFF);
        for (int lane = 0; lane < 4; lane++) begin
            send_item(ACT_WRITE, 7'(lane), 8'hFF, 18'h00000);
        end
        for (int lane = 0; lane < 4; lane++) begin
            send_item(ACT_READ, 7'(lane), 8'h00, 18'h00000);
        end
        send_item(ACT_WRITE, 7'd124, 8'h55, 18'h00000);
        send_item(ACT_WRITE, 7'd125, 8'hAA, 18'h00000);
        send_item(ACT_WRITE, 7'd126, 8'hC0, 18'h00000);
        send_item(ACT_READ, 7'd124, 8'h00, 18'h00000);
        send_item(ACT_READ, 7'd125, 8'h00, 18'h00000);
        send_item(ACT_READ, 7'd126, 8'h00, 18'h00000);

        settle(4);
        write_map_regs(1'b1, 1'b1);
        send_item(ACT_XLATE, 7'd0, 8'h00, 18'h01FFF);
        send_item(ACT_XLATE, 7'd0, 8'h00, 18'h3FFFF);
        send_item(ACT_XLATE, 7'd0, 8'h00, 18'h3E000);
        send_item(ACT_XLATE, 7'd0, 8'h00, 18'h02000);
        send_item(ACT_NONE, 7'd127, 8'hFF, 18'h3FFFF);

        settle(4);
        write_map_regs(1'b1, 1'b0);
        send_item(ACT_XLATE, 7'd0, 8'h00, 18'h3FFFF);

        for (int phase = 0; phase < 8; phase++) begin
            settle(4);
            case (phase)
                2:       write_map_regs(1'b0, 1'b1);
                3:       write_map_regs(1'b1, 1'b0);
                5:       write_map_regs(1'b0, 1'b0);
                default: write_map_regs(1'b1, 1'b1);
            endcase
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            for (int n = 0; n < 100; n++) begin
                pick   = $urandom_range(99);
                offset = REGOFF_W'($urandom);
                wbyte  = BYTE_W'($urandom);
                addr   = BUS_W'($urandom);
                if (pick < 20) begin
                    act = ACT_READ;
                end else if (pick < 45) begin
                    act = ACT_WRITE;
                end else if (pick < 95) begin
                    act = ACT_XLATE;
                end else begin
                    act = ACT_NONE;
                end
                if ($urandom_range(9) == 0) addr[BUS_W-1:OFF_W] = PAGE_IO;
                if ($urandom_range(9) == 0) addr[OFF_W-1:0] = '1;
                send_item(act, offset, wbyte, addr);
            end
        end

        settle(8);
        if (map_errors == 0 && map_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* bus_address_map_registers.f */
hdl/bamr_pkg.sv
hdl/bamr_ram.sv
hdl/bamr_ctrl.sv
hdl/bamr_dp.sv
hdl/bus_address_map_registers.sv
hdl/bamr_chk.sv
test/bamr_map_checker.sv
test/bus_address_map_registers_test.sv
